// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

    // Store geometry.
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the command and result channels.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    // Width that holds both a position and a count for range checks.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ_INDEX = 3'd4,
        CMD_REMOVE_ALT = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMPACT,
        S_HOLD
    } t_state;

    // One result on its way from the sequencer to the output register.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        t_status               status;
        logic [CNT_W-1:0]      fill;
    } t_result;

    // Word returned by a pop from an empty store: only the sign bit set.
    localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

endpackage

// ===== hw/rtl/bdq_if.sv =====
// Command channel: one item is one deque command.
interface bdq_in_if import bdq_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             command;
    logic signed [DATA_WIDTH-1:0] push_value;
    logic [POS_W-1:0]             position;

    modport source (output valid, command, push_value, position, input ready);
    modport sink (input valid, command, push_value, position, output ready);
endinterface

// Result channel: one item per command.
interface bdq_out_if import bdq_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] data_out;
    logic [STATUS_W-1:0]          status;
    logic [CNT_W-1:0]             fill_count;

    modport source (output valid, data_out, status, fill_count, input ready);
    modport sink (input valid, data_out, status, fill_count, output ready);
endinterface

// ===== hw/rtl/bdq_ram.sv =====
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bdq_seq.sv =====
module bdq_seq import bdq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bdq_in_if.sink                i_cmd,
    // Store port.
    output logic                  o_we,
    output logic [ADDR_W-1:0]     o_waddr,
    output logic [DATA_WIDTH-1:0] o_wdata,
    output logic [ADDR_W-1:0]     o_raddr,
    input  logic [DATA_WIDTH-1:0] i_rdata,
    // Result toward the output register.
    output logic                  o_res_valid,
    output t_result               o_res,
    input  logic                  i_res_ready
);

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_kept, n_kept;
    t_result            r_hold, n_hold;

    logic               accept;
    logic [CNT_W:0]     kept_wide;
    logic [CNT_W-1:0]   kept;
    logic [CNT_W-1:0]   k_next;
    logic [CNT_W-1:0]   k_twice;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && (r_state == S_IDLE);

    // Entries kept by a removal: half the count, rounded up.
    assign kept_wide = ({1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1}) >> 1;
    assign kept      = kept_wide[CNT_W-1:0];

    // Next destination offset during compaction and its source offset.
    assign k_next  = r_k + {{(CNT_W-1){1'b0}}, 1'b1};
    assign k_twice = k_next << 1;

    // Control and pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Compaction progress and a stalled result.
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_kept <= n_kept;
        r_hold <= n_hold;
    end

    // Command decode, store access and result forming.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_k         = r_k;
        n_kept      = r_kept;
        n_hold      = r_hold;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_raddr     = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_res_valid = 1'b1;
                    o_res.status = ST_OK;
                    unique case (t_cmd'(i_cmd.command))
                        CMD_PUSH_BACK: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_head + r_count[ADDR_W-1:0];
                                o_wdata = $unsigned(i_cmd.push_value);
                                n_count = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                n_head  = r_head - {{(ADDR_W-1){1'b0}}, 1'b1};
                                o_we    = 1'b1;
                                o_waddr = n_head;
                                o_wdata = $unsigned(i_cmd.push_value);
                                n_count = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                o_res.status = ST_EMPTY;
                                o_res.data   = DATA_MIN;
                            end else begin
                                n_count     = r_count - {{(CNT_W-1){1'b0}}, 1'b1};
                                o_raddr     = r_head + n_count[ADDR_W-1:0];
                                o_res_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                o_res.status = ST_EMPTY;
                                o_res.data   = DATA_MIN;
                            end else begin
                                o_raddr     = r_head;
                                n_head      = r_head + {{(ADDR_W-1){1'b0}}, 1'b1};
                                n_count     = r_count - {{(CNT_W-1){1'b0}}, 1'b1};
                                o_res_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        CMD_READ_INDEX: begin
                            if (CMP_W'(i_cmd.position) >= CMP_W'(r_count)) begin
                                o_res.status = ST_RANGE;
                            end else begin
                                o_raddr     = r_head + ADDR_W'(i_cmd.position);
                                o_res_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        CMD_REMOVE_ALT: begin
                            if (kept <= CNT_W'(1)) begin
                                n_count = kept;
                            end else begin
                                // Start the walk: fetch offset two for slot one.
                                o_raddr     = r_head + ADDR_W'(2);
                                n_k         = CNT_W'(1);
                                n_kept      = kept;
                                o_res_valid = 1'b0;
                                n_state     = S_COMPACT;
                            end
                        end
                        default: begin
                        end
                    endcase
                    o_res.fill = n_count;
                end
            end
            S_READ: begin
                o_res_valid  = 1'b1;
                o_res.data   = i_rdata;
                o_res.status = ST_OK;
                o_res.fill   = r_count;
            end
            S_COMPACT: begin
                // Write the word fetched last cycle, fetch the next one.
                o_we    = 1'b1;
                o_waddr = r_head + r_k[ADDR_W-1:0];
                o_wdata = i_rdata;
                if (k_next < r_kept) begin
                    n_k     = k_next;
                    o_raddr = r_head + k_twice[ADDR_W-1:0];
                end else begin
                    n_count      = r_kept;
                    o_res_valid  = 1'b1;
                    o_res.status = ST_OK;
                    o_res.fill   = r_kept;
                end
            end
            S_HOLD: begin
                o_res_valid = 1'b1;
                o_res       = r_hold;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result over, or park it until the output frees up.
        if (o_res_valid) begin
            if (i_res_ready) begin
                n_state = S_IDLE;
            end else begin
                n_hold  = o_res;
                n_state = S_HOLD;
            end
        end
    end

endmodule

// ===== hw/rtl/bounded_deque_with_alternate_removal.sv =====
// Channel   Dir  Payload                              Handshake
// i_cmd     in   command, push_value, position        valid/ready
// o_res     out  data_out, status, fill_count         valid/ready
//
// A push, an empty pop, a refused request or a removal on a store of two
// entries or fewer is answered straight from the idle state; a pop or a read
// first fetches its word through the store's registered read port. A removal
// moves one word per cycle. Reset clears the pointers and the count; the store
// needs no clearing. A stalled result waits in a hold register and then in the
// output register, and no new item is taken while one is still in the walk.
module bounded_deque_with_alternate_removal import bdq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bdq_in_if.sink  i_cmd,
    bdq_out_if.source o_res
);

    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  res_valid;
    logic                  res_ready;
    t_result               res;

    logic                  r_out_valid;
    t_result               r_out;

    // Entry store.
    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Command sequencer.
    bdq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Output register: takes a new result when empty or being drained.
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.data_out   = $signed(r_out.data);
    assign o_res.status     = r_out.status;
    assign o_res.fill_count = r_out.fill;

endmodule

// ===== bench/bounded_deque_with_alternate_removal_tb.sv =====
module bounded_deque_with_alternate_removal_tb import bdq_pkg::*;;

    localparam int ITEM_TARGET = 850;
    localparam int SHOWN_LIMIT = 10;

    // One command as the sender sees it.
    typedef struct {
        t_cmd                         op;
        logic signed [DATA_WIDTH-1:0] value;
        logic [POS_W-1:0]             pos;
    } t_cmd_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdq_in_if  cmd_if ();
    bdq_out_if res_if ();

    bounded_deque_with_alternate_removal u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Free-running clock with a period of two units.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the deque contents and pointers.
    logic signed [DATA_WIDTH-1:0] deque_mem [DEPTH];
    int front_idx;
    int held;

    t_cmd_item pending_items [$];
    t_result   expected_results [$];
    t_cmd_item in_flight;

    int  items_issued;
    int  items_accepted;
    int  results_checked;
    int  error_count;
    int  send_gap;
    int  recv_gap;
    bit  calm;

    // Run statistics for the closing summary.
    int refused_full;
    int empty_pops;
    int range_reads;
    int removals;
    int peak_fill;

    function automatic int slot(int offset);
        return (front_idx + offset) % DEPTH;
    endfunction

    // Applies one command to the shadow deque and returns the result it should produce.
    function automatic t_result apply_command(t_cmd_item it);
        t_result r;
        int      kept;
        r.data   = '0;
        r.status = ST_OK;
        case (it.op)
            CMD_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                    refused_full++;
                end else begin
                    deque_mem[slot(held)] = it.value;
                    held++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                    refused_full++;
                end else begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    deque_mem[front_idx] = it.value;
                    held++;
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                    r.data   = DATA_MIN;
                    empty_pops++;
                end else if (it.op == CMD_POP_BACK) begin
                    held--;
                    r.data = deque_mem[slot(held)];
                end else begin
                    r.data    = deque_mem[front_idx];
                    front_idx = (front_idx + 1) % DEPTH;
                    held--;
                end
            end
            CMD_READ_INDEX: begin
                if (it.pos >= held) begin
                    r.status = ST_RANGE;
                    range_reads++;
                end else begin
                    r.data = deque_mem[slot(it.pos)];
                end
            end
            CMD_REMOVE_ALT: begin
                // Keep the even positions and close the gaps in order.
                kept = (held + 1) / 2;
                for (int k = 1; k < kept; k++)
                    deque_mem[slot(k)] = deque_mem[slot(2 * k)];
                held = kept;
                removals++;
            end
            default: begin
            end
        endcase
        r.fill = CNT_W'(held);
        if (held > peak_fill)
            peak_fill = held;
        return r;
    endfunction

    // Gap lengths: mostly none or short, now and then long; none at all in calm phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Data words with the extremes showing up now and then.
    function automatic logic signed [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return DATA_MIN;
            1:       return ~DATA_MIN;
            2:       return '0;
            3:       return '1;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // Read positions, half of them aimed inside the current fill.
    function automatic logic [POS_W-1:0] rand_pos();
        if (held > 0 && $urandom_range(0, 1))
            return POS_W'($urandom_range(0, held - 1));
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    task automatic queue_item(t_cmd op, logic signed [DATA_WIDTH-1:0] value,
                              logic [POS_W-1:0] pos);
        t_cmd_item it;
        it.op    = op;
        it.value = value;
        it.pos   = pos;
        pending_items.insert(pending_items.size(), it);
        items_issued++;
    endtask

    // Waits until every queued item has come back as a result.
    task automatic settle();
        while (items_accepted != items_issued || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Pushes until the deque is full and a few more, then probes both ends and sometimes removes alternate entries.
    task automatic fill_phase();
        int needed;
        int done;
        needed = DEPTH - held + $urandom_range(2, 5);
        done   = 0;
        while (done < needed && items_issued < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 12) begin
                queue_item(CMD_READ_INDEX, rand_word(), rand_pos());
            end else begin
                queue_item(t_cmd'($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK),
                           rand_word(), rand_pos());
                done++;
            end
        end
        queue_item(CMD_READ_INDEX, rand_word(), POS_W'(DEPTH - 1));
        queue_item(CMD_READ_INDEX, rand_word(), '0);
        if ($urandom_range(0, 1))
            queue_item(CMD_REMOVE_ALT, rand_word(), rand_pos());
    endtask

    // Pops until the deque is empty and a few more.
    task automatic drain_phase();
        int needed;
        int done;
        needed = held + $urandom_range(1, 3);
        done   = 0;
        while (done < needed && items_issued < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 12) begin
                queue_item(CMD_READ_INDEX, rand_word(), rand_pos());
            end else begin
                queue_item(t_cmd'($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK),
                           rand_word(), rand_pos());
                done++;
            end
        end
    endtask

    // A random mix of every command.
    task automatic mixed_phase();
        int   len;
        int   r;
        t_cmd op;
        len = $urandom_range(40, 80);
        for (int i = 0; i < len && items_issued < ITEM_TARGET; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20)      op = CMD_PUSH_BACK;
            else if (r < 40) op = CMD_PUSH_FRONT;
            else if (r < 55) op = CMD_POP_BACK;
            else if (r < 70) op = CMD_POP_FRONT;
            else if (r < 90) op = CMD_READ_INDEX;
            else             op = CMD_REMOVE_ALT;
            queue_item(op, rand_word(), rand_pos());
        end
    endtask

    // Sender: presents queued items, holds them while stalled, idles between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                expected_results.insert(expected_results.size(), apply_command(in_flight));
                items_accepted++;
                send_gap = pick_gap();
            end
            if (!(cmd_if.valid && !cmd_if.ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_flight = pending_items[0];
                    pending_items.delete(0);
                    cmd_if.valid      <= 1'b1;
                    cmd_if.command    <= in_flight.op;
                    cmd_if.push_value <= in_flight.value;
                    cmd_if.position   <= in_flight.pos;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure and a check of each result against the oldest expected one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= SHOWN_LIMIT)
                        $display("ERROR: unexpected result: data %0d status %0d fill %0d",
                                 res_if.data_out, res_if.status, res_if.fill_count);
                end else begin
                    t_result want;
                    want = expected_results[0];
                    expected_results.delete(0);
                    results_checked++;
                    if (res_if.data_out !== want.data || res_if.status !== want.status ||
                        res_if.fill_count !== want.fill) begin
                        error_count++;
                        if (error_count <= SHOWN_LIMIT)
                            $display({"ERROR: result %0d: data %0d/%0d ",
                                      "status %0d/%0d fill %0d/%0d"},
                                     results_checked, $signed(want.data), res_if.data_out,
                                     want.status, res_if.status, want.fill, res_if.fill_count);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    recv_gap = pick_gap();
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int phase_no;
        cmd_if.valid      = 1'b0;
        cmd_if.command    = CMD_PUSH_BACK;
        cmd_if.push_value = '0;
        cmd_if.position   = '0;
        res_if.ready      = 1'b0;
        i_rst_n           = 1'b0;
        front_idx         = 0;
        held              = 0;
        calm              = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the empty cases, both extremes of the word, wrap of the front pointer.
        queue_item(CMD_POP_BACK, '0, '0);
        queue_item(CMD_POP_FRONT, '0, '0);
        queue_item(CMD_READ_INDEX, '0, '0);
        queue_item(CMD_REMOVE_ALT, '0, '0);
        queue_item(CMD_PUSH_BACK, ~DATA_MIN, '0);
        queue_item(CMD_PUSH_FRONT, DATA_MIN, '0);
        queue_item(CMD_PUSH_BACK, '0, '0);
        queue_item(CMD_PUSH_FRONT, '1, '1);
        queue_item(CMD_READ_INDEX, '0, '0);
        queue_item(CMD_READ_INDEX, '0, 8'd3);
        queue_item(CMD_READ_INDEX, '0, 8'd4);
        queue_item(CMD_READ_INDEX, '0, '1);
        queue_item(CMD_REMOVE_ALT, '0, '0);
        queue_item(CMD_READ_INDEX, '0, 8'd1);
        queue_item(CMD_POP_BACK, '0, '0);
        queue_item(CMD_POP_FRONT, '0, '0);
        queue_item(CMD_PUSH_BACK, 32'sd5, '0);
        queue_item(CMD_REMOVE_ALT, '0, '0);
        queue_item(CMD_POP_FRONT, '0, '0);
        settle();

        // Random phases, each started from a drained pipeline.
        phase_no = 0;
        while (items_issued < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            case (phase_no % 5)
                0:       fill_phase();
                3:       drain_phase();
                default: mixed_phase();
            endcase
            phase_no++;
            settle();
        end

        // Let any stray result show up before closing.
        repeat (300) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            error_count++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end

        $display("Ran %0d commands, checked %0d results, deque peaked at %0d of %0d entries.",
                 items_accepted, results_checked, peak_fill, DEPTH);
        $display("Saw %0d refused pushes, %0d empty pops, %0d out-of-range reads, %0d removals.",
                 refused_full, empty_pops, range_reads, removals);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d errors found.", error_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
